/* hdl/rotation_to_roll_pitch_yaw_top_macros.svh */
// Assertion macros for the rotation to roll, pitch and yaw block.
// Used by the top level only; no other dependencies.
`ifndef ROTATION_TO_ROLL_PITCH_YAW_TOP_MACROS_SVH
`define ROTATION_TO_ROLL_PITCH_YAW_TOP_MACROS_SVH
`ifndef SYNTH
`define RPY_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RPY_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RPY_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RPY_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/rpy_pkg.sv */
// Package for the rotation to roll, pitch and yaw block.
// Holds widths, CORDIC angle table, angle constants and the stage record types.
package rpy_pkg;
   localparam int FRAC_BITS = 16;
   localparam int CORDIC_STAGES = 18;
   localparam int IN_W = 18;
   localparam int OUT_W = 19;
   localparam int GUARD = 14;
   localparam int ANG_FRAC = 30;
   localparam int SQ_W = 37;
   localparam int CP_W = 19;
   localparam int SQRT_STEPS = 19;
   localparam int THR_W = 17;
   // Datapath width: input with guard bits plus growth for the CORDIC gain.
   localparam int DW = IN_W + 1 + GUARD + 3;
   localparam int ZW = 34;
   localparam int SHIFT_OUT = ANG_FRAC - FRAC_BITS;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ZW-1:0] ROUND_Q30 = ZW'(1) <<< (SHIFT_OUT - 1);
   localparam logic signed [OUT_W-1:0] PI_OUT = OUT_W'((PI_Q30 + ROUND_Q30) >>> SHIFT_OUT);
   localparam logic signed [OUT_W-1:0] HALF_PI_OUT =
      OUT_W'((HALF_PI_Q30 + ROUND_Q30) >>> SHIFT_OUT);

   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [ZW-1:0] z;
      logic zero;
   } vec_type;

   typedef struct packed {
      vec_type roll;
      vec_type pitch;
      vec_type yaw;
      logic lock;
      logic neg_pitch;
   } item_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [CP_W-1:0] root;
      logic signed [IN_W:0] r21;
      logic signed [IN_W:0] r22;
      logic signed [IN_W:0] mr20;
      logic signed [IN_W:0] r01;
      logic signed [IN_W:0] r02;
      logic signed [IN_W:0] r10;
      logic signed [IN_W:0] r00;
   } sq_type;

   function automatic logic signed [ZW-1:0] atan_entry(input int k);
      logic signed [ZW-1:0] t;
      begin
         case (k & 31)
            0: t = 34'sd843314856;
            1: t = 34'sd497837829;
            2: t = 34'sd263043836;
            3: t = 34'sd133525158;
            4: t = 34'sd67021686;
            5: t = 34'sd33543515;
            6: t = 34'sd16775850;
            7: t = 34'sd8388437;
            8: t = 34'sd4194282;
            9: t = 34'sd2097149;
            10: t = 34'sd1048575;
            11: t = 34'sd524287;
            12: t = 34'sd262143;
            13: t = 34'sd131071;
            14: t = 34'sd65535;
            15: t = 34'sd32767;
            16: t = 34'sd16383;
            17: t = 34'sd8191;
            18: t = 34'sd4095;
            19: t = 34'sd2047;
            20: t = 34'sd1023;
            21: t = 34'sd511;
            22: t = 34'sd255;
            23: t = 34'sd127;
            24: t = 34'sd63;
            25: t = 34'sd31;
            26: t = 34'sd15;
            27: t = 34'sd7;
            28: t = 34'sd3;
            29: t = 34'sd1;
            default: t = '0;
         endcase
         return t;
      end
   endfunction

   // Sets up one atan2 operand pair with guard bits and the quadrant fold.
   function automatic vec_type vec_init(input logic signed [IN_W:0] y,
                                        input logic signed [IN_W:0] x);
      vec_type v;
      logic signed [DW-1:0] xs;
      logic signed [DW-1:0] ys;
      begin
         xs = DW'(x) <<< GUARD;
         ys = DW'(y) <<< GUARD;
         v.zero = (x == '0) && (y == '0);
         if (xs < 0) begin
            if (ys >= 0) begin
               v.x = ys;
               v.y = -xs;
               v.z = HALF_PI_Q30;
            end else begin
               v.x = -ys;
               v.y = xs;
               v.z = -HALF_PI_Q30;
            end
         end else begin
            v.x = xs;
            v.y = ys;
            v.z = '0;
         end
         return v;
      end
   endfunction

   function automatic vec_type vec_step(input vec_type v, input int k);
      vec_type o;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      begin
         dx = v.y >>> (k & 31);
         dy = v.x >>> (k & 31);
         o = v;
         if (v.y >= 0) begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + atan_entry(k);
         end else begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - atan_entry(k);
         end
         return o;
      end
   endfunction

   function automatic logic signed [OUT_W-1:0] vec_angle(input vec_type v);
      logic signed [ZW-1:0] r;
      begin
         r = (v.z + ZW'(1 << (SHIFT_OUT - 1))) >>> SHIFT_OUT;
         if (v.zero) begin
            return '0;
         end else if (r > ZW'(PI_OUT)) begin
            return PI_OUT;
         end else if (r < -ZW'(PI_OUT)) begin
            return -PI_OUT;
         end
         return OUT_W'(r);
      end
   endfunction
endpackage

/* hdl/rpy_sqrt_cell.sv */
// One cell of the pipelined restoring square root chain.
// Depends on rpy_pkg; resolves one result bit per cycle while en is high.
module rpy_sqrt_cell (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic [4:0] idx,
   input  logic valid_in,
   input  rpy_pkg::sq_type data_in,
   output logic valid_out,
   output rpy_pkg::sq_type data_out
);
   import rpy_pkg::*;
   sq_type data_ff, data_in_c;
   logic valid_ff;
   logic [SQ_W:0] trial;
   logic [SQ_W:0] cur;

   always_comb begin
      data_in_c = data_in;
      cur = {1'b0, data_in.rem} >> (2 * idx);
      trial = {(SQ_W - CP_W - 1)'(0), data_in.root, 2'b01};
      data_in_c.root = data_in.root << 1;
      if (cur >= trial) begin
         data_in_c.rem = data_in.rem - SQ_W'(trial << (2 * idx));
         data_in_c.root = (data_in.root << 1) | CP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         data_ff <= data_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign data_out = data_ff;
endmodule

/* hdl/rpy_cordic_cell.sv */
// One CORDIC vectoring cell shared by the roll, pitch and yaw lanes.
// Depends on rpy_pkg; rotates three vectors by one micro-rotation per cycle while en is high.
module rpy_cordic_cell (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic [4:0] idx,
   input  logic valid_in,
   input  rpy_pkg::item_type data_in,
   output logic valid_out,
   output rpy_pkg::item_type data_out
);
   import rpy_pkg::*;
   item_type data_ff, data_in_c;
   logic valid_ff;

   always_comb begin
      data_in_c = data_in;
      data_in_c.roll = vec_step(data_in.roll, int'(idx));
      data_in_c.pitch = vec_step(data_in.pitch, int'(idx));
      data_in_c.yaw = vec_step(data_in.yaw, int'(idx));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         data_ff <= data_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign data_out = data_ff;
endmodule

/* hdl/rotation_to_roll_pitch_yaw_top.sv */
// A request passes an input register, a 19-cell square root chain, a lock register,
// an 18-cell CORDIC chain and an output register. One transaction per cycle is
// taken, and the whole pipeline advances whenever the output register is empty or
// being taken. Reset is synchronous, clears all valid bits and sets
// lock_threshold to 66.
`include "rotation_to_roll_pitch_yaw_top_macros.svh"
module rotation_to_roll_pitch_yaw_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [rpy_pkg::IN_W-1:0] req_r00,
   input  logic signed [rpy_pkg::IN_W-1:0] req_r01,
   input  logic signed [rpy_pkg::IN_W-1:0] req_r02,
   input  logic signed [rpy_pkg::IN_W-1:0] req_r10,
   input  logic signed [rpy_pkg::IN_W-1:0] req_r20,
   input  logic signed [rpy_pkg::IN_W-1:0] req_r21,
   input  logic signed [rpy_pkg::IN_W-1:0] req_r22,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [rpy_pkg::OUT_W-1:0] rsp_roll_angle,
   output logic signed [rpy_pkg::OUT_W-1:0] rsp_pitch_angle,
   output logic signed [rpy_pkg::OUT_W-1:0] rsp_yaw_angle,
   output logic rsp_gimbal_lock,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rpy_pkg::THR_W-1:0] csr_lock_threshold
);
   import rpy_pkg::*;
   logic en;
   logic [THR_W-1:0] thr_ff;
   logic in_v_ff;
   sq_type in_d_ff, in_d_in;
   logic sq_v [0:SQRT_STEPS];
   sq_type sq_d [0:SQRT_STEPS];
   logic lk_v_ff;
   item_type lk_d_ff, lk_d_in;
   logic co_v [0:CORDIC_STAGES];
   item_type co_d [0:CORDIC_STAGES];
   logic out_v_ff;
   logic signed [OUT_W-1:0] roll_ff, pitch_ff, yaw_ff;
   logic lock_ff;
   logic signed [IN_W:0] mr01, mr02;

   assign en = !out_v_ff || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(66);
      end else if (csr_valid) begin
         thr_ff <= csr_lock_threshold;
      end
   end

   always_comb begin
      in_d_in.r00 = (IN_W + 1)'(req_r00);
      in_d_in.r01 = (IN_W + 1)'(req_r01);
      in_d_in.r02 = (IN_W + 1)'(req_r02);
      in_d_in.r10 = (IN_W + 1)'(req_r10);
      in_d_in.mr20 = -(IN_W + 1)'(req_r20);
      in_d_in.r21 = (IN_W + 1)'(req_r21);
      in_d_in.r22 = (IN_W + 1)'(req_r22);
      in_d_in.root = '0;
      in_d_in.rem = SQ_W'(req_r21 * req_r21) + SQ_W'(req_r22 * req_r22);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_valid;
      end
      if (en) begin
         in_d_ff <= in_d_in;
      end
   end

   assign sq_v[0] = in_v_ff;
   assign sq_d[0] = in_d_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      rpy_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .idx(5'(SQRT_STEPS - 1 - g)),
         .valid_in(sq_v[g]), .data_in(sq_d[g]),
         .valid_out(sq_v[g+1]), .data_out(sq_d[g+1])
      );
   end

   always_comb begin
      mr01 = -sq_d[SQRT_STEPS].r01;
      mr02 = -sq_d[SQRT_STEPS].r02;
      lk_d_in.lock = !({2'b0, sq_d[SQRT_STEPS].root} > (CP_W + 2)'(thr_ff));
      lk_d_in.neg_pitch = !(sq_d[SQRT_STEPS].mr20 > 0);
      lk_d_in.pitch = vec_init(sq_d[SQRT_STEPS].mr20,
                               (IN_W + 1)'(sq_d[SQRT_STEPS].root));
      lk_d_in.yaw = vec_init(sq_d[SQRT_STEPS].r10, sq_d[SQRT_STEPS].r00);
      if (!lk_d_in.lock) begin
         lk_d_in.roll = vec_init(sq_d[SQRT_STEPS].r21, sq_d[SQRT_STEPS].r22);
      end else if (!lk_d_in.neg_pitch) begin
         lk_d_in.roll = vec_init(sq_d[SQRT_STEPS].r01, sq_d[SQRT_STEPS].r02);
      end else begin
         lk_d_in.roll = vec_init(mr01, mr02);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_v_ff <= 1'b0;
      end else if (en) begin
         lk_v_ff <= sq_v[SQRT_STEPS];
      end
      if (en) begin
         lk_d_ff <= lk_d_in;
      end
   end

   assign co_v[0] = lk_v_ff;
   assign co_d[0] = lk_d_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      rpy_cordic_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .idx(5'(g % 32)),
         .valid_in(co_v[g]), .data_in(co_d[g]),
         .valid_out(co_v[g+1]), .data_out(co_d[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= co_v[CORDIC_STAGES];
      end
      if (en) begin
         roll_ff <= vec_angle(co_d[CORDIC_STAGES].roll);
         lock_ff <= co_d[CORDIC_STAGES].lock;
         if (co_d[CORDIC_STAGES].lock) begin
            yaw_ff <= '0;
            pitch_ff <= co_d[CORDIC_STAGES].neg_pitch ? -HALF_PI_OUT : HALF_PI_OUT;
         end else begin
            yaw_ff <= vec_angle(co_d[CORDIC_STAGES].yaw);
            pitch_ff <= vec_angle(co_d[CORDIC_STAGES].pitch);
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_roll_angle = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle = yaw_ff;
   assign rsp_gimbal_lock = lock_ff;

   `RPY_ASSERT_IMPLY(a_lock_yaw, clock, reset, rsp_valid && rsp_gimbal_lock, rsp_yaw_angle == '0)
   `RPY_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_roll_angle))
   `RPY_ASSERT_IMPLY(a_stall, clock, reset, req_stall, rsp_valid && rsp_stall)
endmodule
